// File: hw/rtl/debounced_motor_pwm_control_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor PWM control core
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_MOTOR_PWM_CONTROL_CORE_ASSERT_SVH
`define DEBOUNCED_MOTOR_PWM_CONTROL_CORE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define DMPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DMPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DMPC_ASSERT_NOW(label, ante, cons, msg)
`define DMPC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hw/rtl/dmpc_pkg.sv
// ----------------------------------------------------------------------------
// dmpc_pkg
// Beat types, calibration constants and the ADC-to-compare calibration.
// ----------------------------------------------------------------------------
`default_nettype none

package dmpc_pkg;

    // Input beat: one PWM timer tick
    typedef struct packed {
        logic       sample_strobe;
        logic       power_switch_raw;
        logic       dir_switch_raw;
        logic [9:0] adc_value;
    } in_beat_t;

    // Output beat: drive levels and status for the same tick
    typedef struct packed {
        logic        pwm_out;
        logic        drive_a;
        logic        drive_b;
        logic        motor_on;
        logic [10:0] duty_value;
    } out_beat_t;

    // Reset pattern of the switch histories (alternating, so neither level wins)
    localparam logic [31:0] HIST_RESET_PATTERN = 32'h0000_00AA;

    // Calibration knees
    localparam logic [9:0]  CAL_LOW  = 10'd50;
    localparam logic [9:0]  CAL_HIGH = 10'd1010;
    localparam logic [10:0] CAL_FULL = 11'd1024;

    // d/15 for d <= 960 as (d * 1093) >> 14
    localparam logic [10:0] DIV15_RECIP = 11'd1093;
    localparam int          DIV15_SHIFT = 14;

    // Map a raw ADC reading to a compare value: (v-50)*16/15 = d + d/15
    function automatic logic [10:0] calibrate(input logic [9:0] adc);
        logic [9:0]  diff;
        logic [20:0] prod;
        logic [6:0]  quot;
        diff = adc - CAL_LOW;
        prod = 21'(diff) * 21'(DIV15_RECIP);
        quot = 7'(prod >> DIV15_SHIFT);
        if (adc > CAL_HIGH)
        begin
            calibrate = CAL_FULL;
        end
        else if (adc > CAL_LOW)
        begin
            calibrate = {1'b0, diff} + {4'b0, quot};
        end
        else
        begin
            calibrate = 11'd0;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dmpc_if.sv
// ----------------------------------------------------------------------------
// dmpc channel interfaces
// Valid/ready channels for the tick beats in and the drive beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmpc_in_if;
    logic               valid;
    logic               ready;
    dmpc_pkg::in_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dmpc_out_if;
    logic                valid;
    logic                ready;
    dmpc_pkg::out_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/debounced_motor_pwm_control_core.sv
// ----------------------------------------------------------------------------
// debounced_motor_pwm_control_core
// Switch debounce, power/direction toggles, ADC calibration and PWM generation.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Contents
//  --------+-----+----------------------------------------------------------
//  tick    | in  | sample_strobe, power_switch_raw, dir_switch_raw, adc_value
//  drive   | out | pwm_out, drive_a, drive_b, motor_on, duty_value
//
//  One beat in, one beat out: the state update and result are
//  formed in a single pass and land in the output register at the accept edge.
//  The output register is the only stage; tick.ready stays high while it is
//  empty or being drained, so a beat is taken every cycle when drive is ready.
//  A stall on drive holds the result and blocks tick until it is taken.
//  rst_n clears all control state at once; no start-up sequence.
//
`default_nettype none

module debounced_motor_pwm_control_core #(
    parameter int DEBOUNCE_BITS = 8,
    parameter int PWM_BITS      = 10
) (
    input  wire        clk,
    input  wire        rst_n,
    dmpc_in_if.sink    tick,
    dmpc_out_if.source drive
);

`include "debounced_motor_pwm_control_core_assert.svh"

    localparam int CMP_W = (PWM_BITS > 11) ? PWM_BITS : 11;
    localparam logic [DEBOUNCE_BITS-1:0] HIST_RST =
        DEBOUNCE_BITS'(dmpc_pkg::HIST_RESET_PATTERN);

    // State
    logic [DEBOUNCE_BITS-1:0] power_hist_reg, power_hist_next;
    logic [DEBOUNCE_BITS-1:0] dir_hist_reg, dir_hist_next;
    logic                     power_level_reg, power_level_next;
    logic                     dir_level_reg, dir_level_next;
    logic                     device_on_reg, device_on_next;
    logic                     direction_reg, direction_next;
    logic [PWM_BITS-1:0]      pwm_count_reg, pwm_count_next;
    logic [10:0]              compare_reg, compare_next;

    // Output stage
    logic                     out_valid_reg, out_valid_next;
    dmpc_pkg::out_beat_t      out_payload_reg, out_payload_next;

    logic                     accept;
    logic                     pwm_bit;
    logic [DEBOUNCE_BITS-1:0] power_shift;
    logic [DEBOUNCE_BITS-1:0] dir_shift;
    logic                     power_deb;
    logic                     dir_deb;

    // Take a beat whenever the output register is empty or draining
    assign tick.ready = !out_valid_reg || drive.ready;
    assign accept     = tick.valid && tick.ready;

    // Shift the raw samples into the histories; level moves only on agreement
    always_comb
    begin
        power_shift = {power_hist_reg[DEBOUNCE_BITS-2:0], tick.payload.power_switch_raw};
        dir_shift   = {dir_hist_reg[DEBOUNCE_BITS-2:0], tick.payload.dir_switch_raw};

        if (&power_shift)
        begin
            power_deb = 1'b1;
        end
        else if (~|power_shift)
        begin
            power_deb = 1'b0;
        end
        else
        begin
            power_deb = power_level_reg;
        end

        if (&dir_shift)
        begin
            dir_deb = 1'b1;
        end
        else if (~|dir_shift)
        begin
            dir_deb = 1'b0;
        end
        else
        begin
            dir_deb = dir_level_reg;
        end
    end

    // Next state and result for an accepted beat
    always_comb
    begin
        power_hist_next  = power_hist_reg;
        dir_hist_next    = dir_hist_reg;
        power_level_next = power_level_reg;
        dir_level_next   = dir_level_reg;
        device_on_next   = device_on_reg;
        direction_next   = direction_reg;
        pwm_count_next   = pwm_count_reg;
        compare_next     = compare_reg;
        pwm_bit          = 1'b0;

        // Toggle on debounced release
        if (tick.payload.sample_strobe)
        begin
            power_hist_next  = power_shift;
            dir_hist_next    = dir_shift;
            power_level_next = power_deb;
            dir_level_next   = dir_deb;
            if (power_level_reg && !power_deb)
            begin
                device_on_next = !device_on_reg;
            end
            if (dir_level_reg && !dir_deb)
            begin
                direction_next = !direction_reg;
            end
        end

        // Reload compare and advance the counter only while running
        if (device_on_next)
        begin
            compare_next   = dmpc_pkg::calibrate(tick.payload.adc_value);
            pwm_bit        = CMP_W'(pwm_count_reg) < CMP_W'(compare_next);
            pwm_count_next = pwm_count_reg + PWM_BITS'(1);
        end

        out_payload_next.pwm_out    = pwm_bit;
        out_payload_next.drive_a    = direction_next;
        out_payload_next.drive_b    = !direction_next;
        out_payload_next.motor_on   = device_on_next;
        out_payload_next.duty_value = compare_next;

        out_valid_next = accept || (out_valid_reg && !drive.ready);
    end

    // Hold state; update on accepted beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_hist_reg  <= HIST_RST;
            dir_hist_reg    <= HIST_RST;
            power_level_reg <= 1'b0;
            dir_level_reg   <= 1'b0;
            device_on_reg   <= 1'b0;
            direction_reg   <= 1'b1;
            pwm_count_reg   <= '0;
            compare_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                power_hist_reg  <= power_hist_next;
                dir_hist_reg    <= dir_hist_next;
                power_level_reg <= power_level_next;
                dir_level_reg   <= dir_level_next;
                device_on_reg   <= device_on_next;
                direction_reg   <= direction_next;
                pwm_count_reg   <= pwm_count_next;
                compare_reg     <= compare_next;
            end
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_payload_reg <= out_payload_next;
        end
    end

    assign drive.valid   = out_valid_reg;
    assign drive.payload = out_payload_reg;

    // Checks
    `DMPC_ASSERT_NOW(a_pwm_needs_motor, out_valid_reg && out_payload_reg.pwm_out,
        out_payload_reg.motor_on, "pwm_out high while motor is off")
    `DMPC_ASSERT_NOW(a_duty_range, out_valid_reg,
        out_payload_reg.duty_value <= dmpc_pkg::CAL_FULL, "duty value above full scale")
    `DMPC_ASSERT_NEXT(a_count_holds_off, accept && !device_on_next,
        $stable(pwm_count_reg), "PWM counter moved while motor is off")
    `DMPC_ASSERT_NEXT(a_toggle_on_strobe, !(accept && tick.payload.sample_strobe),
        $stable(device_on_reg) && $stable(direction_reg),
        "power or direction toggled without a sampled beat")

endmodule

`default_nettype wire
